/* sv/sipd_pkg.sv */
package sipd_pkg;

    // field widths
    localparam int PRESSURE_W = 10;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // reset values
    localparam logic [PRESSURE_W-1:0] PRESSURE_RESET       = 10'd512;
    localparam logic [PRESSURE_W-1:0] PUFF_THR_RESET       = 10'd600;
    localparam logic [PRESSURE_W-1:0] SIP_THR_RESET        = 10'd400;
    localparam logic [PRESSURE_W-1:0] STRONG_PUFF_THR_RESET = 10'd800;
    localparam logic [PRESSURE_W-1:0] STRONG_SIP_THR_RESET = 10'd200;
    localparam logic [COUNT_W-1:0]    SETTLE_TICKS_RESET   = 8'd20;
    localparam logic [COUNT_W-1:0]    HOLD_TICKS_RESET     = 8'd5;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PUFF_THR        = 3'd0,
        CFG_SIP_THR         = 3'd1,
        CFG_STRONG_PUFF_THR = 3'd2,
        CFG_STRONG_SIP_THR  = 3'd3,
        CFG_SETTLE_TICKS    = 3'd4,
        CFG_HOLD_TICKS      = 3'd5
    } t_cfg_idx;

    // detector phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_STARTED = 2'd1,
        PH_PRESSED = 2'd2
    } t_phase;

    typedef struct packed {
        logic [PRESSURE_W-1:0] puff_thr;
        logic [PRESSURE_W-1:0] sip_thr;
        logic [PRESSURE_W-1:0] strong_puff_thr;
        logic [PRESSURE_W-1:0] strong_sip_thr;
        logic [COUNT_W-1:0]    settle_ticks;
        logic [COUNT_W-1:0]    hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic press;
        logic release_evt;
    } t_det_ev;

    typedef struct packed {
        logic puff_start;
        logic puff_press;
        logic puff_release;
        logic sip_start;
        logic sip_press;
        logic sip_release;
        logic strong_puff_press;
        logic strong_puff_release;
        logic strong_sip_press;
        logic strong_sip_release;
    } t_events;

endpackage

/* sv/sipd_if.sv */
interface sipd_sample_if import sipd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PRESSURE_W-1:0] pressure;

    modport source(output valid, output pressure, input ready);
    modport sink(input valid, input pressure, output ready);
endinterface

interface sipd_event_if import sipd_pkg::*; ();
    logic valid;
    logic ready;
    logic puff_start;
    logic puff_press;
    logic puff_release;
    logic sip_start;
    logic sip_press;
    logic sip_release;
    logic strong_puff_press;
    logic strong_puff_release;
    logic strong_sip_press;
    logic strong_sip_release;

    modport source(
        output valid, input ready,
        output puff_start, output puff_press, output puff_release,
        output sip_start, output sip_press, output sip_release,
        output strong_puff_press, output strong_puff_release,
        output strong_sip_press, output strong_sip_release
    );
    modport sink(
        input valid, output ready,
        input puff_start, input puff_press, input puff_release,
        input sip_start, input sip_press, input sip_release,
        input strong_puff_press, input strong_puff_release,
        input strong_sip_press, input strong_sip_release
    );
endinterface

interface sipd_cfg_if import sipd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

/* sv/sipd_cfg_regs.sv */
module sipd_cfg_regs import sipd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sipd_cfg_if.sink    i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.puff_thr        <= PUFF_THR_RESET;
            r_cfg.sip_thr         <= SIP_THR_RESET;
            r_cfg.strong_puff_thr <= STRONG_PUFF_THR_RESET;
            r_cfg.strong_sip_thr  <= STRONG_SIP_THR_RESET;
            r_cfg.settle_ticks    <= SETTLE_TICKS_RESET;
            r_cfg.hold_ticks      <= HOLD_TICKS_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PUFF_THR:        r_cfg.puff_thr        <= i_cfg.data;
                CFG_SIP_THR:         r_cfg.sip_thr         <= i_cfg.data;
                CFG_STRONG_PUFF_THR: r_cfg.strong_puff_thr <= i_cfg.data;
                CFG_STRONG_SIP_THR:  r_cfg.strong_sip_thr  <= i_cfg.data;
                CFG_SETTLE_TICKS:    r_cfg.settle_ticks    <= i_cfg.data[COUNT_W-1:0];
                CFG_HOLD_TICKS:      r_cfg.hold_ticks      <= i_cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* sv/sipd_detector.sv */
module sipd_detector import sipd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_beyond,
    input  logic               i_back,
    input  logic               i_moving_on,
    input  logic [COUNT_W-1:0] i_settle_ticks,
    input  logic [COUNT_W-1:0] i_hold_ticks,
    output t_det_ev            o_ev
);

    t_phase             r_phase;
    t_phase             n_phase;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] w_count_dec;

    // count stepped back, not below zero
    assign w_count_dec = (r_count != '0) ? r_count - COUNT_W'(1) : '0;

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // next phase and events
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        o_ev    = '0;
        unique case (r_phase)
            PH_STARTED: begin
                if (!i_moving_on) begin
                    if (r_count > i_settle_ticks) begin
                        n_count  = i_hold_ticks;
                        n_phase  = PH_PRESSED;
                        o_ev.press = 1'b1;
                    end else begin
                        n_count = r_count + COUNT_W'(1);
                    end
                end else begin
                    n_count = w_count_dec;
                end
            end
            PH_PRESSED: begin
                n_count = w_count_dec;
                if (i_back && w_count_dec == '0) begin
                    n_phase          = PH_IDLE;
                    o_ev.release_evt = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_beyond) begin
                    n_phase    = PH_STARTED;
                    n_count    = '0;
                    o_ev.start = 1'b1;
                end
            end
        endcase
    end

    // a press lands in pressed, a release in idle
    a_press_enters_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && o_ev.press |=> r_phase == PH_PRESSED)
        else $error("press did not enter pressed phase");

    a_release_enters_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && o_ev.release_evt |=> r_phase == PH_IDLE)
        else $error("release did not return to idle");

    // at most one event per sample
    a_single_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_ev))
        else $error("more than one detector event at once");

endmodule

/* sv/sip_puff_event_detector.sv */
// Sip and puff event detector.
// i_sample carries one 10-bit pressure sample per transfer (valid/ready).
// i_cfg writes the six control registers by index: 0 puff threshold,
// 1 sip threshold, 2 strong puff threshold, 3 strong sip threshold,
// 4 settle ticks, 5 hold ticks; other indexes are ignored. Write it only
// while no sample is in flight. i_cfg.ready is always high.
// o_event carries one transfer per sample with the start, press and release
// flags of the puff and sip detectors and the press and release flags of
// the strong puff and strong sip detectors. A sample waits in the input
// register, and the detectors update as it moves into the result register,
// from which o_event offers the result.
// Throughput: one sample per cycle while o_event.ready is high;
// the path is one compare stage and an 8-bit counter step per detector.
// Reset clears both pipeline valid flags, sets the detectors idle with zero
// counts, the previous sample to 512 and the registers to their defaults.
// When o_event.ready is low the result holds and one more sample is taken
// into the input register; after that i_sample.ready drops until the
// result is taken.
module sip_puff_event_detector import sipd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sipd_sample_if.sink i_sample,
    sipd_cfg_if.sink    i_cfg,
    sipd_event_if.source o_event
);

    t_cfg                  w_cfg;
    logic                  r_in_valid;
    logic [PRESSURE_W-1:0] r_pressure;
    logic [PRESSURE_W-1:0] r_last_pressure;
    logic                  r_out_valid;
    t_events               r_events;
    t_events               n_events;
    logic                  w_advance;
    logic                  w_rising;
    logic                  w_falling;
    t_det_ev               w_ev_puff;
    t_det_ev               w_ev_sip;
    t_det_ev               w_ev_spuff;
    t_det_ev               w_ev_ssip;

    sipd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // handshake between the two stages
    assign w_advance      = r_in_valid && (!r_out_valid || o_event.ready);
    assign i_sample.ready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.valid && i_sample.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_pressure <= i_sample.pressure;
        end
    end

    // previous sample tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pressure <= PRESSURE_RESET;
        end else if (w_advance) begin
            r_last_pressure <= r_pressure;
        end
    end

    assign w_rising  = r_pressure > r_last_pressure;
    assign w_falling = r_pressure < r_last_pressure;

    // detectors: puff-like look above, sip-like below the threshold
    sipd_detector u_det_puff (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_beyond       (r_pressure > w_cfg.puff_thr),
        .i_back         (r_pressure < w_cfg.puff_thr),
        .i_moving_on    (w_rising),
        .i_settle_ticks (w_cfg.settle_ticks),
        .i_hold_ticks   (w_cfg.hold_ticks),
        .o_ev           (w_ev_puff)
    );

    sipd_detector u_det_sip (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_beyond       (r_pressure < w_cfg.sip_thr),
        .i_back         (r_pressure > w_cfg.sip_thr),
        .i_moving_on    (w_falling),
        .i_settle_ticks (w_cfg.settle_ticks),
        .i_hold_ticks   (w_cfg.hold_ticks),
        .o_ev           (w_ev_sip)
    );

    sipd_detector u_det_strong_puff (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_beyond       (r_pressure > w_cfg.strong_puff_thr),
        .i_back         (r_pressure < w_cfg.strong_puff_thr),
        .i_moving_on    (w_rising),
        .i_settle_ticks (w_cfg.settle_ticks),
        .i_hold_ticks   (w_cfg.hold_ticks),
        .o_ev           (w_ev_spuff)
    );

    sipd_detector u_det_strong_sip (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_beyond       (r_pressure < w_cfg.strong_sip_thr),
        .i_back         (r_pressure > w_cfg.strong_sip_thr),
        .i_moving_on    (w_falling),
        .i_settle_ticks (w_cfg.settle_ticks),
        .i_hold_ticks   (w_cfg.hold_ticks),
        .o_ev           (w_ev_ssip)
    );

    // gather the event flags
    always_comb begin
        n_events.puff_start          = w_ev_puff.start;
        n_events.puff_press          = w_ev_puff.press;
        n_events.puff_release        = w_ev_puff.release_evt;
        n_events.sip_start           = w_ev_sip.start;
        n_events.sip_press           = w_ev_sip.press;
        n_events.sip_release         = w_ev_sip.release_evt;
        n_events.strong_puff_press   = w_ev_spuff.press;
        n_events.strong_puff_release = w_ev_spuff.release_evt;
        n_events.strong_sip_press    = w_ev_ssip.press;
        n_events.strong_sip_release  = w_ev_ssip.release_evt;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_events <= n_events;
        end
    end

    assign o_event.valid               = r_out_valid;
    assign o_event.puff_start          = r_events.puff_start;
    assign o_event.puff_press          = r_events.puff_press;
    assign o_event.puff_release        = r_events.puff_release;
    assign o_event.sip_start           = r_events.sip_start;
    assign o_event.sip_press           = r_events.sip_press;
    assign o_event.sip_release         = r_events.sip_release;
    assign o_event.strong_puff_press   = r_events.strong_puff_press;
    assign o_event.strong_puff_release = r_events.strong_puff_release;
    assign o_event.strong_sip_press    = r_events.strong_sip_press;
    assign o_event.strong_sip_release  = r_events.strong_sip_release;

    // a sample transfer never overwrites a sample that has not moved on
    a_no_input_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sample.valid && i_sample.ready |-> !r_in_valid || w_advance)
        else $error("input register overwritten");

    // every advanced sample shows up as a result
    a_advance_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced sample lost");

    // the previous sample follows each advanced sample
    a_previous_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_last_pressure == $past(r_pressure))
        else $error("previous sample not updated");

endmodule
